// File: rtl/cht_pkg.sv
// Package for the chained hash table unit: request codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package cht_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_SET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_READ,
    ST_CMP,
    ST_FREE,
    ST_INSERT,
    ST_UNLINK,
    ST_DONE
  } state_t;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

// File: rtl/chained_hash_table_unit.sv
// Chained hash table unit: sequencer over the bucket heads, the entry memories
// and the free-entry scan. Depends on cht_pkg.
// Steps: ST_HEAD, then ST_READ and ST_CMP per chain entry; a remove hit adds ST_UNLINK,
// a set miss scans ST_FREE for a free entry, then ST_INSERT, or sets STATUS_FULL.
// One request at a time; in_ready rises the cycle after the result is taken.
// Reset empties every bucket and frees every entry at once.
`timescale 1ns / 1ps
module chained_hash_table_unit #(
  parameter int NUM_BUCKETS  = 16,
  parameter int POOL_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] key,
  input  logic [31:0] value_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [31:0] value_out,
  output logic        status
);

  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int EW = $clog2(POOL_ENTRIES + 1);
  localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam logic [EW-1:0] NIL = EW'(POOL_ENTRIES);
  localparam logic [31:0] NB = 32'(NUM_BUCKETS);

  cht_pkg::state_t state, state_next;

  logic [EW-1:0] heads [NUM_BUCKETS];
  logic [31:0]   ekeys [POOL_ENTRIES];
  logic [31:0]   evals [POOL_ENTRIES];
  logic [EW-1:0] elinks [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] in_use;

  logic [1:0]    op;
  logic [31:0]   rkey, rval;
  logic [BW-1:0] bkt;
  logic [EW-1:0] cur, prev, steps, scan;
  logic [31:0]   rd_key, rd_val;
  logic [EW-1:0] rd_link;

  always_comb begin
    state_next = state;
    case (state)
      cht_pkg::ST_IDLE:   if (in_valid) state_next = cht_pkg::ST_HEAD;
      cht_pkg::ST_HEAD:   state_next = (op == cht_pkg::OP_NONE) ? cht_pkg::ST_DONE
                                                                 : cht_pkg::ST_READ;
      cht_pkg::ST_READ: begin
        if (cur >= NIL || steps == NIL) begin
          state_next = (op == cht_pkg::OP_SET) ? cht_pkg::ST_FREE : cht_pkg::ST_DONE;
        end else begin
          state_next = cht_pkg::ST_CMP;
        end
      end
      cht_pkg::ST_CMP: begin
        if (rd_key == rkey) begin
          state_next = (op == cht_pkg::OP_REMOVE) ? cht_pkg::ST_UNLINK : cht_pkg::ST_DONE;
        end else begin
          state_next = cht_pkg::ST_READ;
        end
      end
      cht_pkg::ST_FREE: begin
        if (scan == NIL) state_next = cht_pkg::ST_DONE;
        else if (!in_use[scan[IW-1:0]]) state_next = cht_pkg::ST_INSERT;
      end
      cht_pkg::ST_INSERT: state_next = cht_pkg::ST_DONE;
      cht_pkg::ST_UNLINK: state_next = cht_pkg::ST_DONE;
      cht_pkg::ST_DONE:   if (out_ready) state_next = cht_pkg::ST_IDLE;
      default:            state_next = cht_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == cht_pkg::ST_IDLE);
    out_valid = (state == cht_pkg::ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cht_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cur < NIL) begin
      rd_key  <= ekeys[cur[IW-1:0]];
      rd_val  <= evals[cur[IW-1:0]];
      rd_link <= elinks[cur[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUCKETS; i++) heads[i] <= NIL;
      in_use <= '0;
    end else begin
      case (state)
        cht_pkg::ST_IDLE: begin
          if (in_valid) begin
            op <= operation;
            rkey <= key;
            rval <= value_in;
            bkt <= BW'(key % NB);
            found <= 1'b0;
            value_out <= '0;
            status <= cht_pkg::STATUS_DONE;
          end
        end
        cht_pkg::ST_HEAD: begin
          cur <= heads[bkt];
          prev <= NIL;
          steps <= '0;
          scan <= '0;
        end
        cht_pkg::ST_READ: steps <= steps + 1'b1;
        cht_pkg::ST_CMP: begin
          if (rd_key == rkey) begin
            found <= 1'b1;
            if (op == cht_pkg::OP_LOOKUP) value_out <= rd_val;
            if (op == cht_pkg::OP_SET) evals[cur[IW-1:0]] <= rval;
          end else begin
            prev <= cur;
            cur <= rd_link;
          end
        end
        cht_pkg::ST_FREE: begin
          if (scan == NIL) status <= cht_pkg::STATUS_FULL;
          else if (in_use[scan[IW-1:0]]) scan <= scan + 1'b1;
        end
        cht_pkg::ST_INSERT: begin
          ekeys[scan[IW-1:0]] <= rkey;
          evals[scan[IW-1:0]] <= rval;
          elinks[scan[IW-1:0]] <= heads[bkt];
          in_use[scan[IW-1:0]] <= 1'b1;
          heads[bkt] <= scan;
        end
        cht_pkg::ST_UNLINK: begin
          if (prev == NIL) heads[bkt] <= rd_link;
          else elinks[prev[IW-1:0]] <= rd_link;
          elinks[cur[IW-1:0]] <= NIL;
          in_use[cur[IW-1:0]] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule
